// ===== src/cbs_pkg.sv =====
// ---------------------------------------------------------------------------
// Centered binomial sampler package
// Shared types and constants for the sampler's front end, queue and back end.
// ---------------------------------------------------------------------------
package cbs_pkg;

	localparam int WORD_W          = 32;
	localparam int COEF_W          = 9;
	localparam int COUNT_W         = 6;
	localparam int LANES           = 8;
	localparam int LANE_W          = 3;
	localparam int NIB_W           = 4;
	localparam int WORDS_PER_HALF  = 6;
	localparam int WORDS_PER_COEF  = 12;
	localparam int WORD_CNT_W      = 4;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_PTR_W     = 1;
	localparam int QUEUE_CNT_W     = 2;

	typedef enum logic {
		KIND_PAIR = 1'b0,
		KIND_SUM  = 1'b1
	} cbs_kind_t;

	typedef enum logic {
		MODE_ETA2   = 1'b0,
		MODE_ETA192 = 1'b1
	} cbs_mode_t;

	typedef struct packed {
		cbs_kind_t           kind;
		logic [WORD_W-1:0]   payload;
	} cbs_entry_t;

	typedef struct packed {
		logic       push;
		cbs_entry_t entry;
	} cbs_push_t;

endpackage

// ===== src/cbs_front.sv =====
// ---------------------------------------------------------------------------
// Centered binomial sampler front end
// Accepts random words, holds the mode, and turns each word either into a
// pair-sampling job or into a step of the popcount difference.
// ---------------------------------------------------------------------------
module cbs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic                            cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [cbs_pkg::WORD_W-1:0]      s_axis_tdata,
	input  logic                            queue_full,
	output cbs_pkg::cbs_push_t              push
);

	cbs_pkg::cbs_mode_t                     mode_q;
	logic [cbs_pkg::WORD_CNT_W-1:0]         word_cnt_q;
	logic signed [cbs_pkg::COEF_W-1:0]      diff_q;
	logic [cbs_pkg::COUNT_W-1:0]            ones;
	logic signed [cbs_pkg::COEF_W-1:0]      ones_s;
	logic signed [cbs_pkg::COEF_W-1:0]      diff_next;
	logic                                   accept;
	logic                                   coef_done;

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign ones          = cbs_pkg::COUNT_W'($countones(s_axis_tdata));
	assign ones_s        = $signed({{(cbs_pkg::COEF_W-cbs_pkg::COUNT_W){1'b0}}, ones});
	assign coef_done     = (word_cnt_q == cbs_pkg::WORD_CNT_W'(cbs_pkg::WORDS_PER_COEF - 1));

	always_comb begin
		if (word_cnt_q < cbs_pkg::WORD_CNT_W'(cbs_pkg::WORDS_PER_HALF)) begin
			diff_next = diff_q + ones_s;
		end else begin
			diff_next = diff_q - ones_s;
		end
	end

	always_comb begin
		push.push          = 1'b0;
		push.entry.kind    = cbs_pkg::KIND_PAIR;
		push.entry.payload = s_axis_tdata;
		if (mode_q == cbs_pkg::MODE_ETA2) begin
			push.push = accept;
		end else begin
			push.push          = accept && coef_done;
			push.entry.kind    = cbs_pkg::KIND_SUM;
			push.entry.payload = {{(cbs_pkg::WORD_W-cbs_pkg::COEF_W){1'b0}}, diff_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= cbs_pkg::MODE_ETA2;
			word_cnt_q <= '0;
			diff_q     <= '0;
		end else if (cfg_wen) begin
			mode_q     <= cbs_pkg::cbs_mode_t'(cfg_wdata);
			word_cnt_q <= '0;
			diff_q     <= '0;
		end else if (accept && mode_q == cbs_pkg::MODE_ETA192) begin
			if (coef_done) begin
				word_cnt_q <= '0;
				diff_q     <= '0;
			end else begin
				word_cnt_q <= word_cnt_q + 1'b1;
				diff_q     <= diff_next;
			end
		end
	end

endmodule

// ===== src/cbs_queue.sv =====
// ---------------------------------------------------------------------------
// Centered binomial sampler job queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module cbs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbs_pkg::cbs_push_t   push,
	input  logic                 pop,
	output cbs_pkg::cbs_entry_t  head,
	output logic                 empty,
	output logic                 full
);

	cbs_pkg::cbs_entry_t                 slot_q [cbs_pkg::QUEUE_DEPTH];
	logic [cbs_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [cbs_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [cbs_pkg::QUEUE_CNT_W-1:0]     count_q;
	logic                                do_push;
	logic                                do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == cbs_pkg::QUEUE_CNT_W'(cbs_pkg::QUEUE_DEPTH));
	assign do_push = push.push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/cbs_back.sv =====
// ---------------------------------------------------------------------------
// Centered binomial sampler back end
// Drains queued jobs into coefficients, one per cycle unless stalled, tracks
// the position in the polynomial and holds the output register.
// ---------------------------------------------------------------------------
module cbs_back #(
	parameter int POLY_COEFFS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  cbs_pkg::cbs_entry_t           head,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,
	output logic                          m_axis_tlast,
	output logic                          m_axis_tuser
);

	localparam int IDX_W = $clog2(POLY_COEFFS);

	logic [cbs_pkg::LANE_W-1:0]           lane_q;
	logic [IDX_W-1:0]                     idx_q;
	logic                                 out_valid_q;
	logic signed [cbs_pkg::COEF_W-1:0]    coef_q;
	logic                                 run_last_q;
	logic                                 poly_last_q;
	logic [cbs_pkg::NIB_W-1:0]            nib;
	logic [1:0]                           sum_lo;
	logic [1:0]                           sum_hi;
	logic signed [cbs_pkg::COEF_W-1:0]    coef;
	logic                                 run_last;
	logic                                 poly_last;
	logic                                 advance;

	assign advance   = !empty && (!out_valid_q || m_axis_tready);
	assign nib       = head.payload[{lane_q, 2'b00} +: cbs_pkg::NIB_W];
	assign sum_lo    = {1'b0, nib[0]} + {1'b0, nib[1]};
	assign sum_hi    = {1'b0, nib[2]} + {1'b0, nib[3]};
	assign run_last  = (head.kind == cbs_pkg::KIND_SUM) ||
	                   (lane_q == cbs_pkg::LANE_W'(cbs_pkg::LANES - 1));
	assign poly_last = (idx_q == IDX_W'(POLY_COEFFS - 1));
	assign pop       = advance && run_last;

	always_comb begin
		if (head.kind == cbs_pkg::KIND_SUM) begin
			coef = $signed(head.payload[cbs_pkg::COEF_W-1:0]);
		end else begin
			coef = $signed({{(cbs_pkg::COEF_W-2){1'b0}}, sum_lo}) -
			       $signed({{(cbs_pkg::COEF_W-2){1'b0}}, sum_hi});
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coef_q      <= coef;
			run_last_q  <= run_last;
			poly_last_q <= poly_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_wen) begin
			lane_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				lane_q      <= run_last ? '0 : lane_q + 1'b1;
				idx_q       <= poly_last ? '0 : idx_q + 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16-cbs_pkg::COEF_W){1'b0}}, coef_q};
	assign m_axis_tlast  = poly_last_q;
	assign m_axis_tuser  = run_last_q;

endmodule

// ===== src/centered_binomial_sampler.sv =====
// An accepted word's job goes through the job queue into the back end's output register.
// Throughput: in eta 2 mode the back end emits one coefficient per cycle while
// the output is ready; in eta 192 mode a word is taken every cycle while the
// two-entry job queue has room, which lets the input run ahead of a stalled output.
// Reset clears the mode to eta 2 and all counters; mode writes spare the queue's.
// ---------------------------------------------------------------------------
// Centered binomial sampler
// Turns a stream of random words into centered binomial coefficients.
// ---------------------------------------------------------------------------
module centered_binomial_sampler #(
	parameter int POLY_COEFFS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,      // sampler_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // random_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // coefficient [8:0], zero fill above
	output logic        m_axis_tlast,   // poly_last
	output logic        m_axis_tuser    // run_last
);

	cbs_pkg::cbs_push_t  push;
	cbs_pkg::cbs_entry_t head;
	logic                empty;
	logic                full;
	logic                pop;

	cbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.queue_full    (full),
		.push          (push)
	);

	cbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	cbs_back #(
		.POLY_COEFFS (POLY_COEFFS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== src/cbs_checker.sv =====
// ---------------------------------------------------------------------------
// Centered binomial sampler checker
// Port-level assertions on the sampler's output stream.
// ---------------------------------------------------------------------------
module cbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic        cfg_wdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic               mode_q;
	logic signed [8:0]  coef;

	assign coef = $signed(m_axis_tdata[8:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
		else $error("padding bits of output beat are not zero");

	a_wide_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> coef >= -9'sd192 && coef <= 9'sd192)
		else $error("coefficient outside -192..192");

	a_eta2_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !mode_q |-> coef >= -9'sd2 && coef <= 9'sd2)
		else $error("eta 2 coefficient outside -2..2");

	a_eta192_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mode_q |-> m_axis_tuser)
		else $error("eta 192 beat without run end flag");

endmodule

bind centered_binomial_sampler cbs_checker u_cbs_checker (.*);
